FILE: hw/rtl/credit_based_traffic_shaper_assert.svh
// Assertion macros used by the traffic shaper checker.
`ifndef CREDIT_BASED_TRAFFIC_SHAPER_ASSERT_SVH
`define CREDIT_BASED_TRAFFIC_SHAPER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CBTS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CBTS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/cbts_pkg.sv
// Types, widths and codes of the credit-based traffic shaper.
`timescale 1ns / 1ps
`default_nettype none
package cbts_pkg;

   localparam int CREDIT_W = 48;
   localparam int LEVEL_W  = 20;
   localparam int HOLD_W   = 28;
   localparam int SLOPE_W  = 24;
   localparam int TPB_W    = 8;
   localparam int OVH_W    = 6;
   localparam int CMD_W    = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 48;

   typedef logic [CMD_W-1:0] cmd_type;
   localparam cmd_type CMD_TICK  = 2'd0;
   localparam cmd_type CMD_LEVEL = 2'd1;
   localparam cmd_type CMD_IDLE  = 2'd2;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type REG_IDLE_CREDIT = 2'd0;
   localparam csr_idx_type REG_SEND_CREDIT = 2'd1;
   localparam csr_idx_type REG_TICKS_BYTE  = 2'd2;
   localparam csr_idx_type REG_OVERHEAD    = 2'd3;

   localparam logic [SLOPE_W-1:0] IDLE_CREDIT_RST = '0;
   localparam logic [SLOPE_W-1:0] SEND_CREDIT_RST = '0;
   localparam logic [TPB_W-1:0]   TICKS_BYTE_RST  = 8'd1;
   localparam logic [OVH_W-1:0]   OVERHEAD_RST    = 6'd20;

   typedef struct packed {
      logic [SLOPE_W-1:0] idle_credit;
      logic [SLOPE_W-1:0] send_credit;
      logic [TPB_W-1:0]   ticks_per_byte;
      logic [OVH_W-1:0]   overhead;
   } cfg_type;

   typedef struct packed {
      logic signed [CREDIT_W-1:0] credit;
      logic [LEVEL_W-1:0]         queue_bytes;
      logic [HOLD_W-1:0]          hold_ticks;
      logic                       transmitting;
   } state_type;

endpackage
`default_nettype wire

FILE: hw/rtl/credit_based_traffic_shaper.sv
// Top level of the credit-based traffic shaper for one traffic class.
//
//  channel  dir  handshake            payload
//  req      in   req_tvalid/tready    tuser: cmd; tdata: queue_level
//  rsp      out  rsp_tvalid/tready    tuser: gate_open; tdata: credit_now
//  csr      in   csr_valid/csr_ready  csr_index, csr_data
//
// One word per cycle while the result is not stalled; a taken word passes from the input
// register through the update logic into the result register.
// The credit loop is the path that sets the clock: one 21x24 multiply, 49-bit subtract, clamp.
// Reset (synchronous) clears credit, queue, hold and both pipeline stages, and loads
// register defaults. A stalled result blocks the input only once the input register is full.
`timescale 1ns / 1ps
`default_nettype none
module credit_based_traffic_shaper (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [cbts_pkg::REQ_DATA_W-1:0]     req_tdata,   // [19:0] queue_level, [23:20] zero
   input  logic [cbts_pkg::CMD_W-1:0]          req_tuser,   // [1:0] cmd
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [cbts_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // [47:0] credit_now
   output logic                                rsp_tuser,   // [0] gate_open
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cbts_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cbts_pkg::CSR_DATA_W-1:0]     csr_data
);
   import cbts_pkg::*;

   cfg_type                 cfg_ff, cfg_in;
   state_type               state_ff, state_nxt;
   logic                    in_vld_ff;
   cmd_type                 in_cmd_ff;
   logic [LEVEL_W-1:0]      in_level_ff;
   logic                    out_vld_ff, out_vld_in;
   logic [CREDIT_W-1:0]     out_credit_ff;
   logic                    out_gate_ff;
   logic                    advance;
   logic                    req_take;

   assign csr_ready = 1'b1;
   assign advance   = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign req_take  = req_tvalid && req_tready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_IDLE_CREDIT: cfg_in.idle_credit    = csr_data[SLOPE_W-1:0];
            REG_SEND_CREDIT: cfg_in.send_credit    = csr_data[SLOPE_W-1:0];
            REG_TICKS_BYTE:  cfg_in.ticks_per_byte = csr_data[TPB_W-1:0];
            REG_OVERHEAD:    cfg_in.overhead       = csr_data[OVH_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.idle_credit    <= IDLE_CREDIT_RST;
         cfg_ff.send_credit    <= SEND_CREDIT_RST;
         cfg_ff.ticks_per_byte <= TICKS_BYTE_RST;
         cfg_ff.overhead       <= OVERHEAD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input register: hold the word until the update stage takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff   <= req_tuser;
         in_level_ff <= req_tdata[LEVEL_W-1:0];
      end
   end

   cbts_update u_update (
      .cfg   (cfg_ff),
      .cur   (state_ff),
      .cmd   (in_cmd_ff),
      .level (in_level_ff),
      .nxt   (state_nxt)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_nxt;
      end
   end

   assign out_vld_in = advance || (out_vld_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_credit_ff <= state_nxt.credit;
         out_gate_ff   <= !state_nxt.credit[CREDIT_W-1];
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_credit_ff;
   assign rsp_tuser  = out_gate_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/cbts_update.sv
// Next-state logic of the shaper: one word's effect on credit, queue and hold.
`timescale 1ns / 1ps
`default_nettype none
module cbts_update (
   input  cbts_pkg::cfg_type                 cfg,
   input  cbts_pkg::state_type               cur,
   input  cbts_pkg::cmd_type                 cmd,
   input  logic [cbts_pkg::LEVEL_W-1:0]      level,
   output cbts_pkg::state_type               nxt
);
   import cbts_pkg::*;

   localparam int BYTES_W = LEVEL_W + 1;
   localparam int COST_W  = BYTES_W + SLOPE_W;
   localparam int HPROD_W = BYTES_W + TPB_W;

   logic [BYTES_W-1:0]       bytes;
   logic [COST_W-1:0]        cost;
   logic [HPROD_W-1:0]       hold_prod;
   logic signed [CREDIT_W:0] add_sum;
   logic signed [CREDIT_W:0] sub_sum;
   logic signed [CREDIT_W-1:0] add_sat;
   logic signed [CREDIT_W-1:0] sub_sat;
   logic                     q_empty;

   function automatic logic signed [CREDIT_W-1:0] sat48(input logic signed [CREDIT_W:0] v);
      logic signed [CREDIT_W-1:0] r;
      if (v[CREDIT_W] != v[CREDIT_W-1]) begin
         r = v[CREDIT_W] ? {1'b1, {(CREDIT_W-1){1'b0}}} : {1'b0, {(CREDIT_W-1){1'b1}}};
      end else begin
         r = v[CREDIT_W-1:0];
      end
      return r;
   endfunction

   // Drop positive credit to zero.
   function automatic logic signed [CREDIT_W-1:0] zero_pos(input logic signed [CREDIT_W-1:0] c);
      logic signed [CREDIT_W-1:0] r;
      r = (!c[CREDIT_W-1] && (c != '0)) ? '0 : c;
      return r;
   endfunction

   assign bytes = BYTES_W'(cur.queue_bytes - level) + BYTES_W'(cfg.overhead);
   assign cost      = COST_W'(bytes) * COST_W'(cfg.send_credit);
   assign hold_prod = HPROD_W'(bytes) * HPROD_W'(cfg.ticks_per_byte);
   assign add_sum = {cur.credit[CREDIT_W-1], cur.credit} +
                    $signed({{(CREDIT_W+1-SLOPE_W){1'b0}}, cfg.idle_credit});
   assign sub_sum = {cur.credit[CREDIT_W-1], cur.credit} -
                    $signed({{(CREDIT_W+1-COST_W){1'b0}}, cost});
   assign add_sat = sat48(add_sum);
   assign sub_sat = sat48(sub_sum);
   assign q_empty = (cur.queue_bytes == '0);

   always_comb begin
      nxt = cur;
      case (cmd)
         CMD_TICK: begin
            if (cur.hold_ticks != '0) begin
               nxt.hold_ticks = cur.hold_ticks - HOLD_W'(1);
            end else begin
               nxt.credit = q_empty ? zero_pos(add_sat) : add_sat;
            end
         end
         CMD_LEVEL: begin
            nxt.queue_bytes = level;
            if (level > cur.queue_bytes) begin
               if (q_empty) begin
                  nxt.credit = zero_pos(cur.credit);
               end
            end else if (level < cur.queue_bytes) begin
               nxt.credit       = sub_sat;
               nxt.hold_ticks   = hold_prod[HOLD_W-1:0];
               nxt.transmitting = 1'b1;
            end
         end
         CMD_IDLE: begin
            nxt.transmitting = 1'b0;
            if (q_empty) begin
               nxt.credit = zero_pos(cur.credit);
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule
`default_nettype wire

FILE: hw/rtl/cbts_checker.sv
// Port-level checks of the traffic shaper, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "credit_based_traffic_shaper_assert.svh"
module cbts_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [cbts_pkg::REQ_DATA_W-1:0]     req_tdata,   // [19:0] queue_level, [23:20] zero
   input  logic [cbts_pkg::CMD_W-1:0]          req_tuser,   // [1:0] cmd
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [cbts_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // [47:0] credit_now
   input  logic                                rsp_tuser,   // [0] gate_open
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [cbts_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cbts_pkg::CSR_DATA_W-1:0]     csr_data
);
   import cbts_pkg::*;

   // A stalled result word stays put.
   `CBTS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

   // Gate flag follows the credit sign.
   `CBTS_ASSERT_IMPL(a_gate_sign, clock, reset, rsp_tvalid, rsp_tuser == !rsp_tdata[CREDIT_W-1], "gate does not match credit sign")

   // Input backpressure only comes from a full result register.
   `CBTS_ASSERT_IMPL(a_stall_cause, clock, reset, !req_tready, rsp_tvalid, "input stalled with empty result register")

   // No result right after reset.
   `CBTS_ASSERT_IMPL(a_reset_empty, clock, reset, $past(reset), !rsp_tvalid, "result valid after reset")

endmodule

bind credit_based_traffic_shaper cbts_checker u_cbts_checker (.*);
`default_nettype wire
